FILE: sv/fsc_pkg.sv
// Package for the frame sequence checker: sequencer state and disposition types,
// the frame rate scale constant and the configuration register indexes.
// Has no dependencies; the checker core imports it.
`default_nettype none

package fsc_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CLASS   = 10'b00_0000_0010,
        S_UPDATE  = 10'b00_0000_0100,
        S_LOAD    = 10'b00_0000_1000,
        S_AVG     = 10'b00_0001_0000,
        S_MUL_HI  = 10'b00_0010_0000,
        S_MUL_ADD = 10'b00_0100_0000,
        S_CMP     = 10'b00_1000_0000,
        S_RATE    = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } t_state;

    // Frame disposition as reported on the result tuser.
    typedef enum logic [1:0] {
        DISP_ACCEPTED  = 2'd0,
        DISP_DUPLICATE = 2'd1,
        DISP_OUT_ORDER = 2'd2,
        DISP_RESTARTED = 2'd3
    } t_disp;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RESTART_MAX_START = 2'd0;
    localparam logic [1:0] CFG_RESTART_MIN_JUMP  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [31:0] RESET_MAX_START = 32'd30;
    localparam logic [31:0] RESET_MIN_JUMP  = 32'd100;

    // Frame rate in Q8: advance sum times 1e6 times 256 over delta sum.
    localparam logic [27:0] RATE_SCALE = 28'd256000000;
    localparam int          RATE_BITS  = 24;
    localparam int          AVG_STEPS  = 64;

    // Caps of the result fields.
    localparam logic [31:0] CAP32 = 32'hFFFF_FFFF;
    localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

FILE: sv/frame_sequence_checker_core.sv
// Frame sequence checker core: classifies received frames, keeps loss,
// reorder and timing statistics, and divides them on one shared divider.
// Depends on fsc_pkg.
`default_nettype none

// Every input transfer produces a result; when the frame rate saturates, the rate
// division is skipped. The input is taken again in the cycle after the result is
// loaded into the output register, so one frame is finished before the next is taken.
// The sequence runs on the one-bit-per-step shared divider: 64 steps for the
// average delta and 24 steps for the rate. Reset is synchronous and active low;
// it clears all statistics and restores the configuration defaults.
module frame_sequence_checker_core
    import fsc_pkg::*;
#(
    parameter int FRAME_BITS = 32,
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input frame stream.
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata, lowest bit up: frame_number[31:0], timestamp_us[79:32].
    input  wire logic [79:0]  i_s_axis_tdata,
    // Result stream.
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata, lowest bit up: accepted_count[31:0], missing_total[63:32],
    // largest_gap[95:64], duplicate_count[127:96], out_of_order_count[159:128],
    // restart_count[191:160], nonmonotonic_count[223:192], min_delta_us[271:224],
    // max_delta_us[319:272], average_delta_us[367:320], rate_q8[391:368].
    output logic [391:0]      o_m_axis_tdata,
    // tuser: disposition[1:0].
    output logic [1:0]        o_m_axis_tuser,
    // Configuration write channel.
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    localparam logic [COUNT_BITS-1:0] CMAX    = '1;
    localparam int                    CNT_W   = $clog2(AVG_STEPS);
    localparam logic [CNT_W-1:0]      AVG_TOP = CNT_W'(AVG_STEPS - 1);
    localparam logic [CNT_W-1:0]      RATE_TOP = CNT_W'(RATE_BITS - 1);

    // Saturating counter increment.
    function automatic logic [COUNT_BITS-1:0] inc_cnt(input logic [COUNT_BITS-1:0] a);
        return (a == CMAX) ? a : a + 1'b1;
    endfunction

    // Counter plus a wide amount, saturating at the counter's maximum.
    function automatic logic [COUNT_BITS-1:0] add_cnt(input logic [COUNT_BITS-1:0] a,
                                                      input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return (s > 65'(CMAX)) ? CMAX : COUNT_BITS'(s);
    endfunction

    // 64-bit saturating add.
    function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] cap_cnt(input logic [COUNT_BITS-1:0] v);
        return (64'(v) > 64'(CAP32)) ? CAP32 : 32'(v);
    endfunction

    function automatic logic [47:0] cap_time(input logic [63:0] v);
        return (v > 64'(CAP48)) ? CAP48 : 48'(v);
    endfunction

    // Sequencer.
    t_state r_state, n_state;

    // Configuration.
    logic [31:0] r_max_start, r_min_jump;

    // Statistics.
    logic                  r_has_accepted;
    logic [FRAME_BITS-1:0] r_last_frame;
    logic [TIME_BITS-1:0]  r_last_time;
    logic [COUNT_BITS-1:0] r_accepted, r_missing_sum, r_gap_peak, r_dup_total;
    logic [COUNT_BITS-1:0] r_order_total, r_restart_total, r_nonmono_total;
    logic [COUNT_BITS-1:0] r_sample_count;
    logic [TIME_BITS-1:0]  r_delta_min, r_delta_max;
    logic [63:0]           r_delta_sum, r_advance_sum;

    // Current frame and its classification.
    logic [FRAME_BITS-1:0] r_in_frame, r_adv;
    logic [TIME_BITS-1:0]  r_in_ts, r_delta;
    t_disp                 r_disp;
    logic                  r_first, r_ts_up;

    // Shared divider and rate product.
    logic [63:0]    r_rem, r_dvd, r_divisor, r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [95:0]    r_prod;
    logic [59:0]    r_part;
    logic [47:0]    r_avg;
    logic           r_sat;

    // Output register.
    logic           r_m_valid;
    logic [391:0]   r_m_data;
    logic [1:0]     r_m_user;

    // Classification of the held frame against the last accepted frame.
    logic                  c_eq, c_lt, c_ts_up, c_restart;
    logic [FRAME_BITS-1:0] c_jump;
    logic [FRAME_BITS-1:0] u_missing;
    logic [COUNT_BITS-1:0] u_miss_cap;

    // Shared subtractor: one restoring division step, or the rate range check.
    logic [64:0] sub_a;
    logic [63:0] sub_b;
    logic [65:0] sub_diff;
    logic        sub_take;

    logic [31:0] mul_a;
    logic [59:0] mul_p;

    logic in_xfer, out_free;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;

    assign c_eq      = (r_in_frame == r_last_frame);
    assign c_lt      = (r_in_frame < r_last_frame);
    assign c_ts_up   = (r_in_ts > r_last_time);
    assign c_jump    = r_last_frame - r_in_frame;
    assign c_restart = (64'(r_in_frame) <= 64'(r_max_start))
                    && (64'(c_jump) >= 64'(r_min_jump)) && c_ts_up;

    assign u_missing  = r_adv - 1'b1;
    assign u_miss_cap = (65'(u_missing) > 65'(CMAX)) ? CMAX : COUNT_BITS'(u_missing);

    always_comb begin
        if (r_state == S_CMP) begin
            sub_a = {1'b0, r_prod[87:24]};
            sub_b = r_delta_sum;
        end else begin
            sub_a = {r_rem, r_dvd[63]};
            sub_b = r_divisor;
        end
    end

    assign sub_diff = {1'b0, sub_a} - {2'b00, sub_b};
    assign sub_take = !sub_diff[65];

    // One 32 by 28 multiplier, used for the low and then the high half.
    assign mul_a = (r_state == S_LOAD) ? r_advance_sum[31:0] : r_advance_sum[63:32];
    assign mul_p = mul_a * RATE_SCALE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_xfer) n_state = S_CLASS;
            S_CLASS:   n_state = S_UPDATE;
            S_UPDATE:  n_state = S_LOAD;
            S_LOAD:    n_state = S_AVG;
            S_AVG:     if (r_cnt == '0) n_state = S_MUL_HI;
            S_MUL_HI:  n_state = S_MUL_ADD;
            S_MUL_ADD: n_state = S_CMP;
            // A quotient that reaches bit 24 or beyond saturates at once.
            S_CMP:     n_state = ((r_prod[95:88] != '0) || sub_take) ? S_OUT : S_RATE;
            S_RATE:    if (r_cnt == '0) n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_max_start     <= RESET_MAX_START;
            r_min_jump      <= RESET_MIN_JUMP;
            r_has_accepted  <= 1'b0;
            r_last_frame    <= '0;
            r_last_time     <= '0;
            r_accepted      <= '0;
            r_missing_sum   <= '0;
            r_gap_peak      <= '0;
            r_dup_total     <= '0;
            r_order_total   <= '0;
            r_restart_total <= '0;
            r_nonmono_total <= '0;
            r_sample_count  <= '0;
            r_delta_min     <= '0;
            r_delta_max     <= '0;
            r_delta_sum     <= '0;
            r_advance_sum   <= '0;
            r_m_valid       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RESTART_MAX_START) begin
                    r_max_start <= i_cfg_data;
                end else if (i_cfg_index == CFG_RESTART_MIN_JUMP) begin
                    r_min_jump <= i_cfg_data;
                end
            end

            if (r_state == S_UPDATE) begin
                if (r_first) begin
                    r_has_accepted <= 1'b1;
                    r_last_frame   <= r_in_frame;
                    r_last_time    <= r_in_ts;
                    r_accepted     <= inc_cnt(r_accepted);
                end else begin
                    case (r_disp)
                        DISP_DUPLICATE: r_dup_total <= inc_cnt(r_dup_total);
                        DISP_OUT_ORDER: r_order_total <= inc_cnt(r_order_total);
                        DISP_RESTARTED: begin
                            r_restart_total <= inc_cnt(r_restart_total);
                            r_accepted      <= inc_cnt(r_accepted);
                            r_last_frame    <= r_in_frame;
                            r_last_time     <= r_in_ts;
                        end
                        default: begin
                            // Forward frame: loss statistics, and a timing sample or a nonmonotonic count.
                            r_missing_sum <= add_cnt(r_missing_sum, 64'(u_missing));
                            if (u_miss_cap > r_gap_peak) begin
                                r_gap_peak <= u_miss_cap;
                            end
                            if (r_ts_up) begin
                                if (r_sample_count == '0) begin
                                    r_delta_min <= r_delta;
                                    r_delta_max <= r_delta;
                                end else begin
                                    if (r_delta < r_delta_min) r_delta_min <= r_delta;
                                    if (r_delta > r_delta_max) r_delta_max <= r_delta;
                                end
                                // A full sample counter freezes both sums with it.
                                if (r_sample_count != CMAX) begin
                                    r_sample_count <= r_sample_count + 1'b1;
                                    r_delta_sum    <= add64(r_delta_sum, 64'(r_delta));
                                    r_advance_sum  <= add64(r_advance_sum, 64'(r_adv));
                                end
                            end else begin
                                r_nonmono_total <= inc_cnt(r_nonmono_total);
                            end
                            r_accepted   <= inc_cnt(r_accepted);
                            r_last_frame <= r_in_frame;
                            r_last_time  <= r_in_ts;
                        end
                    endcase
                end
            end

            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_in_frame <= FRAME_BITS'(i_s_axis_tdata[31:0]);
                    r_in_ts    <= TIME_BITS'(i_s_axis_tdata[79:32]);
                end
            end
            S_CLASS: begin
                r_first <= !r_has_accepted;
                r_ts_up <= c_ts_up;
                r_adv   <= r_in_frame - r_last_frame;
                r_delta <= r_in_ts - r_last_time;
                if (!r_has_accepted) begin
                    r_disp <= DISP_ACCEPTED;
                end else if (c_eq) begin
                    r_disp <= DISP_DUPLICATE;
                end else if (c_lt) begin
                    r_disp <= c_restart ? DISP_RESTARTED : DISP_OUT_ORDER;
                end else begin
                    r_disp <= DISP_ACCEPTED;
                end
            end
            S_LOAD: begin
                // Average delta: delta sum over sample count.
                r_rem     <= '0;
                r_dvd     <= r_delta_sum;
                r_divisor <= 64'(r_sample_count);
                r_quo     <= '0;
                r_cnt     <= AVG_TOP;
                r_prod    <= 96'(mul_p);
            end
            S_AVG, S_RATE: begin
                r_rem <= sub_take ? sub_diff[63:0] : sub_a[63:0];
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_quo <= {r_quo[62:0], sub_take};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MUL_HI: begin
                r_avg  <= (r_sample_count == '0) ? '0 : cap_time(r_quo);
                r_part <= mul_p;
            end
            S_MUL_ADD: begin
                r_prod[95:32] <= r_prod[95:32] + 64'(r_part);
            end
            S_CMP: begin
                // Upper dividend bits already below the divisor become the remainder.
                r_sat     <= (r_prod[95:88] != '0) || sub_take;
                r_rem     <= r_prod[87:24];
                r_dvd     <= {r_prod[23:0], 40'd0};
                r_divisor <= r_delta_sum;
                r_quo     <= '0;
                r_cnt     <= RATE_TOP;
            end
            S_OUT: begin
                if (out_free) begin
                    r_m_user <= r_disp;
                    r_m_data <= {
                        (r_delta_sum == '0) ? 24'd0 : (r_sat ? 24'hFF_FFFF : r_quo[23:0]),
                        r_avg,
                        cap_time(64'(r_delta_max)),
                        cap_time(64'(r_delta_min)),
                        cap_cnt(r_nonmono_total),
                        cap_cnt(r_restart_total),
                        cap_cnt(r_order_total),
                        cap_cnt(r_dup_total),
                        cap_cnt(r_gap_peak),
                        cap_cnt(r_missing_sum),
                        cap_cnt(r_accepted)
                    };
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CLASS))
        else $error("input transfer did not start classification");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sample_count != '0) |-> (r_delta_min <= r_delta_max))
        else $error("minimum delta above maximum delta");

    a_gap_le_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_peak <= r_missing_sum)
        else $error("largest gap above missing total");

    a_sum_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_delta_sum != '0) |-> (r_sample_count != '0))
        else $error("delta sum without samples");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Testbench for frame_sequence_checker_core: drives frames over the input stream,
// predicts every result with its own model of the statistics and compares them.
// Depends on fsc_pkg and frame_sequence_checker_core.
`timescale 1ns / 1ps

module testbench;
    import fsc_pkg::*;

    localparam logic [1:0]  CFG_SPARE_2 = 2'd2;   // unused register slots, must be ignored
    localparam logic [1:0]  CFG_SPARE_3 = 2'd3;
    localparam logic [63:0] COUNT_TOP   = 64'hFFFF_FFFF;
    localparam logic [63:0] SUM_TOP     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] FRAME_TOP   = 32'hFFFF_FFFF;
    localparam logic [47:0] STAMP_TOP   = 48'hFFFF_FFFF_FFFF;
    localparam int          RANDOM_PHASES    = 6;
    localparam int          FRAMES_PER_PHASE = 200;

    // Result tdata laid out as a packed struct; the first member is the highest.
    typedef struct packed {
        logic [23:0] rate_q8;
        logic [47:0] avg_us;
        logic [47:0] max_us;
        logic [47:0] min_us;
        logic [31:0] nonmono;
        logic [31:0] restarts;
        logic [31:0] out_of_order;
        logic [31:0] duplicates;
        logic [31:0] peak_gap;
        logic [31:0] missing;
        logic [31:0] accepted;
    } t_frame_stats;

    typedef struct packed {
        t_disp        disp;
        t_frame_stats stats;
    } t_frame_report;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [79:0]  i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [391:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    frame_sequence_checker_core dut (.*);

    always #2 i_clk = ~i_clk;

    // Predicted state of the checker, starting from the reset values.
    logic [31:0] cfg_max_start = RESET_MAX_START;
    logic [31:0] cfg_min_jump  = RESET_MIN_JUMP;
    bit          seen_first;
    logic [31:0] prev_frame = '0;
    logic [47:0] prev_time = '0;
    logic [31:0] n_accepted = '0, n_missing = '0, peak_gap = '0, n_dup = '0;
    logic [31:0] n_ooo = '0, n_restart = '0, n_nonmono = '0;
    logic [31:0] n_samples = '0;
    logic [47:0] interval_min = '0, interval_max = '0;
    logic [63:0] interval_sum = '0, advance_total = '0;

    t_frame_report pending_reports[$];
    int          mismatch_count;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] top);
        if (a >= top || b > top - a)
            return top;
        return a + b;
    endfunction

    function automatic int unsigned draw_pause(input bit enabled);
        return enabled ? $urandom_range(0, 15) : 0;
    endfunction

    // Classifies one frame, updates the statistics and queues the report it should produce.
    function automatic void predict_frame(input logic [31:0] number, input logic [47:0] stamp);
        t_frame_report r;
        logic [31:0]   advance;
        logic [31:0]   skipped;
        logic [47:0]   delta;
        logic [63:0]   mean;
        logic [127:0]  quotient;
        r.disp = DISP_ACCEPTED;
        if (!seen_first) begin
            seen_first = 1'b1;
            prev_frame = number;
            prev_time  = stamp;
            n_accepted = 32'(sat_add(n_accepted, 1, COUNT_TOP));
        end else if (number == prev_frame) begin
            n_dup  = 32'(sat_add(n_dup, 1, COUNT_TOP));
            r.disp = DISP_DUPLICATE;
        end else if (number < prev_frame) begin
            if (number <= cfg_max_start && prev_frame - number >= cfg_min_jump
                    && stamp > prev_time) begin
                n_restart  = 32'(sat_add(n_restart, 1, COUNT_TOP));
                n_accepted = 32'(sat_add(n_accepted, 1, COUNT_TOP));
                prev_frame = number;
                prev_time  = stamp;
                r.disp     = DISP_RESTARTED;
            end else begin
                n_ooo  = 32'(sat_add(n_ooo, 1, COUNT_TOP));
                r.disp = DISP_OUT_ORDER;
            end
        end else begin
            advance   = number - prev_frame;
            skipped   = advance - 1;
            n_missing = 32'(sat_add(n_missing, skipped, COUNT_TOP));
            if (skipped > peak_gap)
                peak_gap = skipped;
            if (stamp > prev_time) begin
                delta = stamp - prev_time;
                if (n_samples == 0) begin
                    interval_min = delta;
                    interval_max = delta;
                end else begin
                    if (delta < interval_min) interval_min = delta;
                    if (delta > interval_max) interval_max = delta;
                end
                // A full sample counter freezes the sums so average and rate stay consistent.
                if (n_samples != FRAME_TOP) begin
                    n_samples     = n_samples + 1;
                    interval_sum  = sat_add(interval_sum, 64'(delta), SUM_TOP);
                    advance_total = sat_add(advance_total, 64'(advance), SUM_TOP);
                end
            end else begin
                n_nonmono = 32'(sat_add(n_nonmono, 1, COUNT_TOP));
            end
            n_accepted = 32'(sat_add(n_accepted, 1, COUNT_TOP));
            prev_frame = number;
            prev_time  = stamp;
        end

        r.stats.accepted     = n_accepted;
        r.stats.missing      = n_missing;
        r.stats.peak_gap     = peak_gap;
        r.stats.duplicates   = n_dup;
        r.stats.out_of_order = n_ooo;
        r.stats.restarts     = n_restart;
        r.stats.nonmono      = n_nonmono;
        r.stats.min_us       = interval_min;
        r.stats.max_us       = interval_max;
        if (n_samples == 0) begin
            r.stats.avg_us = '0;
        end else begin
            mean = interval_sum / 64'(n_samples);
            r.stats.avg_us = (mean > 64'(STAMP_TOP)) ? STAMP_TOP : mean[47:0];
        end
        if (interval_sum == 0) begin
            r.stats.rate_q8 = '0;
        end else begin
            quotient = (128'(advance_total) * 128'(RATE_SCALE)) / 128'(interval_sum);
            r.stats.rate_q8 = (quotient > 128'(24'hFF_FFFF)) ? 24'hFF_FFFF : quotient[23:0];
        end
        pending_reports.push_back(r);
    endfunction

    // Presents one frame and waits for its transfer; valid is left high so a
    // back-to-back frame needs no extra assignment in the same step.
    task automatic send_frame(input logic [31:0] number, input logic [47:0] stamp);
        int unsigned pause;
        pause = draw_pause(tx_idle_on);
        if (pause != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {stamp, number};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_frame(number, stamp);
    endtask

    // Drops the input valid and waits until every predicted report has arrived.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (index)
            CFG_RESTART_MAX_START: cfg_max_start = value;
            CFG_RESTART_MIN_JUMP:  cfg_min_jump  = value;
            default: ;
        endcase
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", field, want, seen);
            mismatch_count++;
        end
    endtask

    // Default registers: first frame, duplicate, restart boundaries, extreme
    // numbers and timestamps, rate saturation and missing-count saturation.
    task automatic test_directed_classes();
        send_frame(FRAME_TOP, '0);          // first frame is always accepted
        send_frame(FRAME_TOP, STAMP_TOP);   // duplicate
        send_frame(32'd5, '0);              // restart shape but timestamp not newer
        send_frame(32'd0, 48'd1000);        // restart
        send_frame(FRAME_TOP, 48'd1001);    // huge advance over 1 us: rate saturates
        send_frame(32'd10, 48'd5000);       // restart
        send_frame(FRAME_TOP, 48'd5000);    // missing total saturates, flat timestamp
        send_frame(32'd30, 48'd6000);       // restart at the highest allowed number
        send_frame(32'd130, 48'd7000);
        send_frame(32'd31, 48'd7100);       // just above the restart limit
        send_frame(32'd30, 48'd8000);       // jump of exactly the minimum
        send_frame(32'd129, 48'd9000);
        send_frame(32'd30, 48'd9500);       // jump one short of the minimum
        send_frame(32'd200, STAMP_TOP);     // largest possible timestamp
        send_frame(32'd201, '0);            // timestamp going backward
        send_frame(32'd202, 48'd33333);
    endtask

    // Both registers at their extremes, a zero minimum jump, and writes to unused indexes.
    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_RESTART_MAX_START, FRAME_TOP);
        write_reg(CFG_RESTART_MIN_JUMP, '0);
        write_reg(CFG_SPARE_2, FRAME_TOP);
        write_reg(CFG_SPARE_3, '0);
        send_frame(32'd1000, 48'd100000);
        send_frame(32'd999, 48'd200000);    // a jump of one is enough now
        wait_idle();
        write_reg(CFG_RESTART_MAX_START, '0);
        write_reg(CFG_RESTART_MIN_JUMP, FRAME_TOP);
        send_frame(32'd0, 48'd400000);      // jump too short
        send_frame(FRAME_TOP, 48'd400001);
        send_frame(32'd0, 48'd400002);      // the only jump that qualifies
        wait_idle();
        write_reg(CFG_RESTART_MIN_JUMP, 32'd1);
        write_reg(CFG_RESTART_MAX_START, RESET_MAX_START);
        send_frame(32'd5, 48'd500000);
        send_frame(32'd4, 48'd600000);
    endtask

    // Mostly a well-formed stream with small skips and video-like timestamps,
    // salted with duplicates, late frames, restarts and fully random frames.
    task automatic test_random_stream(input int phase);
        int unsigned pick;
        logic [31:0] number;
        logic [47:0] stamp;
        logic [47:0] step;
        logic [31:0] bound;
        wait_idle();
        tx_idle_on = (phase % 3) != 1 && phase != 4;
        rx_idle_on = (phase % 3) != 2 && phase != 4;
        case ($urandom_range(0, 4))
            0: write_reg(CFG_RESTART_MAX_START, '0);
            1: write_reg(CFG_RESTART_MAX_START, FRAME_TOP);
            2: write_reg(CFG_RESTART_MAX_START, $urandom);
            default: write_reg(CFG_RESTART_MAX_START, $urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 4))
            0: write_reg(CFG_RESTART_MIN_JUMP, '0);
            1: write_reg(CFG_RESTART_MIN_JUMP, FRAME_TOP);
            2: write_reg(CFG_RESTART_MIN_JUMP, 32'd1);
            default: write_reg(CFG_RESTART_MIN_JUMP, $urandom_range(1, 500));
        endcase
        for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
            pick = $urandom_range(0, 99);
            step = ($urandom_range(0, 9) == 0) ? 48'($urandom_range(1, 3))
                                               : 48'($urandom_range(30000, 36000));
            stamp = prev_time + step;
            if (pick < 70) begin
                if ($urandom_range(0, 49) == 0)
                    number = $urandom;
                else if ($urandom_range(0, 9) == 0)
                    number = prev_frame + $urandom_range(2, 50);
                else
                    number = prev_frame + 1;
                if (number <= prev_frame)
                    number = $urandom;
                if ($urandom_range(0, 19) == 0)
                    stamp = prev_time - 48'($urandom_range(0, 1000));
            end else if (pick < 78) begin
                number = prev_frame;
            end else if (pick < 86) begin
                number = prev_frame - $urandom_range(1, 5);
            end else if (pick < 94) begin
                bound  = (cfg_max_start > 32'd1000) ? 32'd1000 : cfg_max_start;
                number = $urandom_range(0, bound);
                if ($urandom_range(0, 7) == 0)
                    stamp = prev_time;
            end else begin
                number = $urandom;
                stamp  = {16'($urandom), 32'($urandom)};
            end
            send_frame(number, stamp);
        end
    endtask

    // Result side: a random stall before each result, or none in eager stretches.
    initial begin : result_sink
        int unsigned pause;
        @(posedge i_clk iff i_rst_n);
        forever begin
            pause = draw_pause(rx_idle_on);
            if (pause != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Every result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_frame_report want;
        t_frame_stats  seen;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result transfer with no frame outstanding");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                seen = t_frame_stats'(o_m_axis_tdata);
                compare_field("disposition", 64'(want.disp), 64'(o_m_axis_tuser));
                compare_field("accepted_count", 64'(want.stats.accepted), 64'(seen.accepted));
                compare_field("missing_total", 64'(want.stats.missing), 64'(seen.missing));
                compare_field("largest_gap", 64'(want.stats.peak_gap), 64'(seen.peak_gap));
                compare_field("duplicate_count", 64'(want.stats.duplicates),
                              64'(seen.duplicates));
                compare_field("out_of_order_count", 64'(want.stats.out_of_order),
                              64'(seen.out_of_order));
                compare_field("restart_count", 64'(want.stats.restarts), 64'(seen.restarts));
                compare_field("nonmonotonic_count", 64'(want.stats.nonmono),
                              64'(seen.nonmono));
                compare_field("min_delta_us", 64'(want.stats.min_us), 64'(seen.min_us));
                compare_field("max_delta_us", 64'(want.stats.max_us), 64'(seen.max_us));
                compare_field("average_delta_us", 64'(want.stats.avg_us), 64'(seen.avg_us));
                compare_field("rate_q8", 64'(want.stats.rate_q8), 64'(seen.rate_q8));
            end
        end
    end

    initial begin : run
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_classes();
        test_register_extremes();
        for (int p = 0; p < RANDOM_PHASES; p++)
            test_random_stream(p);
        wait_idle();
        // Allow a full frame latency for any stray result to show up.
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
sv/fsc_pkg.sv
sv/frame_sequence_checker_core.sv
sim/testbench.sv
